// ===== design/sbo_pkg.sv =====
package sbo_pkg;

    localparam int NUM_IRREPS  = 8;
    localparam int LANE_W      = 3;
    localparam int SYM_W       = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int OUT_W       = 23;
    localparam int TOTAL_INDEX = 8;

    // Highest rank of the structures that the block builds offsets for.
    localparam int MAX_RANK = 2;

    typedef enum logic {
        OP_VECTOR = 1'b0,
        OP_MATRIX = 1'b1
    } sbo_op_t;

    typedef enum logic {
        LAYOUT_GENERAL = 1'b0,
        LAYOUT_PACKED  = 1'b1
    } sbo_layout_t;

    typedef logic [OUT_W-1:0] sbo_term_t;

    typedef struct packed {
        logic                  valid;
        logic                  bad;
        logic [NUM_IRREPS-1:0] mask;
    } sbo_ctl_t;

endpackage

// ===== design/sbo_terms.sv =====
module sbo_terms #(
    parameter int DIM_WIDTH = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        operation,
    input  logic [sbo_pkg::SYM_W-1:0]   sym_first,
    input  logic [sbo_pkg::SYM_W-1:0]   sym_second,
    input  logic                        packed_req,
    input  logic [DIM_WIDTH-1:0]        dims [sbo_pkg::NUM_IRREPS],
    output sbo_pkg::sbo_ctl_t           ctl_reg,
    output sbo_pkg::sbo_term_t          terms_reg [sbo_pkg::NUM_IRREPS]
);

    import sbo_pkg::*;

    localparam int PW = 2 * DIM_WIDTH + 1;
    localparam int EW = (PW > OUT_W) ? PW : OUT_W;

    logic [LANE_W-1:0]    sym;
    logic [LANE_W-1:0]    partner;
    logic [SYM_W-1:0]     packed_limit;
    logic                 bad;
    logic [LANE_W-1:0]    lane    [NUM_IRREPS];
    logic [LANE_W-1:0]    mate    [NUM_IRREPS];
    logic                 diag    [NUM_IRREPS];
    logic [DIM_WIDTH:0]   op_b    [NUM_IRREPS];
    logic [PW-1:0]        prod    [NUM_IRREPS];
    logic [EW-1:0]        wide    [NUM_IRREPS];
    logic [NUM_IRREPS-1:0] mask;
    sbo_ctl_t             ctl_next;
    sbo_term_t            terms_next [NUM_IRREPS];

    always_comb
    begin
        sym     = sym_first[LANE_W-1:0];
        partner = sym_second[LANE_W-1:0] ^ sym;

        if (sym_second >= SYM_W'(TOTAL_INDEX))
        begin
            packed_limit = SYM_W'(NUM_IRREPS);
        end
        else if (sym_second[LANE_W-1:0] >= partner)
        begin
            packed_limit = {1'b0, sym_second[LANE_W-1:0]};
        end
        else
        begin
            packed_limit = {1'b0, partner};
        end

        if (operation == OP_VECTOR)
        begin
            bad = (sym_first > SYM_W'(TOTAL_INDEX));
        end
        else
        begin
            bad = (MAX_RANK < 2) || (sym_first >= SYM_W'(NUM_IRREPS)) ||
                  (sym_second > SYM_W'(TOTAL_INDEX));
        end

        for (int k = 0; k < NUM_IRREPS; k++)
        begin
            lane[k] = LANE_W'(k);
            mate[k] = lane[k] ^ sym;
            diag[k] = (mate[k] == lane[k]);
            op_b[k] = (diag[k] && (packed_req == LAYOUT_PACKED))
                    ? ({1'b0, dims[k]} + (DIM_WIDTH+1)'(1))
                    : {1'b0, dims[mate[k]]};
            prod[k] = PW'(dims[k]) * PW'(op_b[k]);

            if (operation == OP_VECTOR)
            begin
                wide[k] = EW'(dims[k]);
                mask[k] = (MAX_RANK >= 1) && ({1'b0, lane[k]} < sym_first);
            end
            else if (packed_req == LAYOUT_PACKED)
            begin
                wide[k] = diag[k] ? EW'(prod[k] >> 1) : EW'(prod[k]);
                mask[k] = ({1'b0, lane[k]} < packed_limit) && (lane[k] >= mate[k]);
            end
            else
            begin
                wide[k] = EW'(prod[k]);
                mask[k] = ({1'b0, lane[k]} < sym_second);
            end

            terms_next[k] = wide[k][OUT_W-1:0];
        end

        ctl_next.valid = accept;
        ctl_next.bad   = bad;
        ctl_next.mask  = bad ? '0 : mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        terms_reg <= terms_next;
    end

endmodule

// ===== design/sbo_sum.sv =====
module sbo_sum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbo_pkg::sbo_ctl_t           ctl,
    input  sbo_pkg::sbo_term_t          terms [sbo_pkg::NUM_IRREPS],
    output logic                        valid_reg,
    output logic [sbo_pkg::OUT_W-1:0]   offset_reg,
    output logic                        bad_reg
);

    import sbo_pkg::*;

    logic [OUT_W-1:0] offset_next;

    always_comb
    begin
        offset_next = '0;
        for (int k = 0; k < NUM_IRREPS; k++)
        begin
            if (ctl.mask[k])
            begin
                offset_next = offset_next + terms[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        bad_reg    <= ctl.bad;
    end

endmodule

// ===== design/symmetry_block_offset_calc.sv =====
// Pipeline: a query taken at a clock edge passes through the term register and then the result
// register; result_valid is high for a single cycle while that result is on the ports.
// Throughput: one query per cycle; the eight lane multipliers feed a term register and a
// masked adder feeds the result register, so busy stays low.
// Reset: rst_n clears the irrep dimensions to zero and drops every pending result strobe.
// The receiver cannot stall; each result is shown for exactly one cycle.
module symmetry_block_offset_calc #(
    parameter int DIM_WIDTH = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [sbo_pkg::SYM_W-1:0]     sym_first,
    input  logic [sbo_pkg::SYM_W-1:0]     sym_second,
    input  logic                          packed_req,
    input  logic                          cfg_we,
    input  logic [sbo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_WIDTH-1:0]          cfg_data,
    output logic                          result_valid,
    output logic [sbo_pkg::OUT_W-1:0]     offset_value,
    output logic                          bad_query
);

    import sbo_pkg::*;

    logic [DIM_WIDTH-1:0] dims_reg [NUM_IRREPS];
    logic                 accept;
    sbo_ctl_t             ctl;
    sbo_term_t            terms [NUM_IRREPS];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_IRREPS; k++)
            begin
                dims_reg[k] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_IRREPS)))
        begin
            dims_reg[cfg_index[LANE_W-1:0]] <= cfg_data;
        end
    end

    sbo_terms #(
        .DIM_WIDTH (DIM_WIDTH)
    ) u_terms (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .sym_first  (sym_first),
        .sym_second (sym_second),
        .packed_req (packed_req),
        .dims       (dims_reg),
        .ctl_reg    (ctl),
        .terms_reg  (terms)
    );

    sbo_sum u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .terms      (terms),
        .valid_reg  (result_valid),
        .offset_reg (offset_value),
        .bad_reg    (bad_query)
    );

endmodule

// ===== design/sbo_checker.sv =====
module sbo_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          operation,
    input logic [sbo_pkg::SYM_W-1:0]     sym_first,
    input logic                          result_valid,
    input logic [sbo_pkg::OUT_W-1:0]     offset_value,
    input logic                          bad_query
);

    import sbo_pkg::*;

    // Every accepted beat yields exactly one result, through the term and result registers.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 result_valid)
        else $error("accepted query produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##1 !result_valid)
        else $error("result without an accepted query");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && bad_query) |-> (offset_value == '0))
        else $error("rejected query carries a non-zero offset");

    a_vector_first: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_VECTOR && sym_first == '0)
        |=> ##1 (offset_value == '0 && !bad_query))
        else $error("offset of the first irrep is not zero");

    a_bad_symmetry: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_MATRIX && sym_first >= SYM_W'(NUM_IRREPS))
        |=> ##1 bad_query)
        else $error("matrix query with invalid symmetry not flagged");

endmodule

bind symmetry_block_offset_calc sbo_checker u_sbo_checker (.*);
